FILE: hw/rtl/arpc_pkg.sv
// Shared types, codes and sizes for the ARP cache resolver.
// Used by every module of the block; depends on nothing.
package arpc_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int IP_W        = 32;
	localparam int MAC_W       = 48;
	localparam int IDX_OUT_W   = 3;
	localparam int KIND_W      = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 48;

	// input actions
	localparam logic [1:0] ACT_RESOLVE = 2'd0;
	localparam logic [1:0] ACT_REPLY   = 2'd1;
	localparam logic [1:0] ACT_REQUEST = 2'd2;
	localparam logic [1:0] ACT_NONE    = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_HIT     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REQ     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LEARNED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd4;

	// entry states
	localparam logic [1:0] ST_FREE       = 2'd0;
	localparam logic [1:0] ST_INCOMPLETE = 2'd1;
	localparam logic [1:0] ST_COMPLETE   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b1;

	typedef struct packed {
		logic [1:0]       op;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic             pkt;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [MAC_W-1:0]     mac;
		logic [IP_W-1:0]      ip;
		logic                 flush;
		logic [IDX_OUT_W-1:0] idx;
	} res_t;

	typedef struct packed {
		logic push;
		logic full;
	} qctl_t;

endpackage

FILE: hw/rtl/arpc_front.sv
// Front end: takes command words, drops unused actions, queues the rest.
// Depends on arpc_pkg.
module arpc_front (
	input  logic                 start,
	input  logic [1:0]           action,
	input  logic [31:0]          ip_addr,
	input  logic [47:0]          mac_addr,
	input  logic                 has_packet,
	input  logic                 q_full,
	output logic                 busy,
	output arpc_pkg::qctl_t      qctl,
	output arpc_pkg::item_t      item
);
	import arpc_pkg::*;

	logic keep;

	always_comb begin
		unique case (action)
			ACT_RESOLVE, ACT_REPLY, ACT_REQUEST: keep = 1'b1;
			default: keep = 1'b0;
		endcase
	end

	assign busy      = q_full;
	assign qctl.full = q_full;
	// an unused action is taken and dropped without a result
	assign qctl.push = start && !q_full && keep;

	always_comb begin
		item.op  = action;
		item.ip  = ip_addr;
		item.mac = mac_addr;
		// the waiting mark only means something on a resolve
		item.pkt = has_packet && (action == ACT_RESOLVE);
	end

endmodule

FILE: hw/rtl/arpc_queue.sv
// Two-word queue between front and back end.
// Depends on arpc_pkg.
module arpc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  arpc_pkg::item_t din,
	input  logic            pop,
	output arpc_pkg::item_t dout,
	output logic            full,
	output logic            empty
);
	import arpc_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: hw/rtl/arpc_back.sv
// Back end: entry table, compare stage and execute/write-back stage.
// Depends on arpc_pkg.
module arpc_back #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  arpc_pkg::item_t q_item,
	output logic            pop,
	output logic            done,
	output arpc_pkg::res_t  res
);
	import arpc_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [1:0]       st_q   [ENTRIES];
	logic [IP_W-1:0]  ip_q   [ENTRIES];
	logic [MAC_W-1:0] mac_q  [ENTRIES];
	logic             wait_q [ENTRIES];

	logic               valid_s1;
	item_t              item_s1;
	logic [ENTRIES-1:0] match_s1;
	logic [ENTRIES-1:0] free_s1;

	logic          hit;
	logic          free_any;
	logic [IW-1:0] hit_idx;
	logic [IW-1:0] free_idx;
	logic [IW-1:0] sel;
	logic          hit_done;
	res_t          res_d;
	logic          done_q;
	res_t          res_q;

	function automatic logic [IW-1:0] first_set(input logic [ENTRIES-1:0] v);
		logic [IW-1:0] r;
		r = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = IW'(i);
			end
		end
		return r;
	endfunction

	// one word in flight: compare, then execute, so the compare sees the last write
	assign pop = !q_empty && !valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= q_item;
			for (int i = 0; i < ENTRIES; i++) begin
				match_s1[i] <= (ip_q[i] == q_item.ip);
				free_s1[i]  <= (st_q[i] == ST_FREE);
			end
		end
	end

	assign hit      = |match_s1;
	assign free_any = |free_s1;
	assign hit_idx  = first_set(match_s1);
	assign free_idx = first_set(free_s1);
	// claim order: matching entry, then lowest free, then entry 0
	assign sel      = hit ? hit_idx : (free_any ? free_idx : '0);
	assign hit_done = hit && (st_q[hit_idx] == ST_COMPLETE);

	always_comb begin
		res_d.kind  = KIND_REPLY;
		res_d.mac   = item_s1.mac;
		res_d.ip    = item_s1.ip;
		res_d.flush = 1'b0;
		res_d.idx   = '0;
		case (item_s1.op)
			ACT_RESOLVE: begin
				if (hit_done) begin
					res_d.kind = KIND_HIT;
					res_d.mac  = mac_q[hit_idx];
					res_d.idx  = IDX_OUT_W'(hit_idx);
				end else begin
					res_d.kind = KIND_REQ;
					res_d.mac  = '0;
					res_d.idx  = IDX_OUT_W'(sel);
				end
			end
			ACT_REPLY: begin
				if (hit) begin
					res_d.kind  = KIND_LEARNED;
					res_d.flush = wait_q[hit_idx];
					res_d.idx   = IDX_OUT_W'(hit_idx);
				end else begin
					res_d.kind = KIND_IGNORED;
					res_d.mac  = '0;
				end
			end
			default: begin
				res_d.kind = KIND_REPLY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				st_q[i]   <= ST_FREE;
				ip_q[i]   <= '0;
				mac_q[i]  <= '0;
				wait_q[i] <= 1'b0;
			end
		end else if (valid_s1) begin
			case (item_s1.op)
				ACT_RESOLVE: begin
					if (!hit_done) begin
						st_q[sel] <= ST_INCOMPLETE;
						if (!hit) begin
							ip_q[sel] <= item_s1.ip;
						end
						if (item_s1.pkt) begin
							wait_q[sel] <= 1'b1;
						end
					end
				end
				ACT_REPLY: begin
					if (hit) begin
						mac_q[hit_idx]  <= item_s1.mac;
						wait_q[hit_idx] <= 1'b0;
						st_q[hit_idx]   <= ST_COMPLETE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: hw/rtl/arp_cache_resolver_unit.sv
// Top level of the ARP cache resolver: front end, queue, back end, config registers.
// Depends on arpc_pkg, arpc_front, arpc_queue and arpc_back.
//
//  channel   handshake             word
//  command   start && !busy        action, ip_addr, mac_addr, has_packet
//  config    cfg_valid && ready    cfg_index, cfg_data
//  result    done (one cycle)      kind, mac_out, ip_out, flush_pending, entry_index
//
// The back end holds one word at a time (compare, then execute and write back) and
// takes no new word until it is through with the last, so results never come back
// to back. A taken word goes through the queue, the compare stage and the result
// register, and waits in the queue while older words are served. The two-word queue
// lets the front take words while the back end works; busy is high only while it is
// full. Reset clears the whole table to free with IP and MAC zero. Results cannot be held off by the receiver.
module arp_cache_resolver_unit #(
	parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          action,
	input  logic [arpc_pkg::IP_W-1:0]           ip_addr,
	input  logic [arpc_pkg::MAC_W-1:0]          mac_addr,
	input  logic                                has_packet,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [arpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                done,
	output logic [arpc_pkg::KIND_W-1:0]         kind,
	output logic [arpc_pkg::MAC_W-1:0]          mac_out,
	output logic [arpc_pkg::IP_W-1:0]           ip_out,
	output logic                                flush_pending,
	output logic [arpc_pkg::IDX_OUT_W-1:0]      entry_index
);
	import arpc_pkg::*;

	qctl_t      qctl;
	item_t      f_item;
	item_t      q_item;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	res_t       res;
	// sender addresses, set through the config channel; no output carries them
	logic [MAC_W-1:0] own_mac_q;
	logic [IP_W-1:0]  own_ip_q;

	arpc_front u_front (
		.start      (start),
		.action     (action),
		.ip_addr    (ip_addr),
		.mac_addr   (mac_addr),
		.has_packet (has_packet),
		.q_full     (q_full),
		.busy       (busy),
		.qctl       (qctl),
		.item       (f_item)
	);

	arpc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (qctl.push),
		.din    (f_item),
		.pop    (q_pop),
		.dout   (q_item),
		.full   (q_full),
		.empty  (q_empty)
	);

	arpc_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_item),
		.pop     (q_pop),
		.done    (done),
		.res     (res)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q <= '0;
			own_ip_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OWN_MAC: own_mac_q <= cfg_data[MAC_W-1:0];
				CFG_OWN_IP:  own_ip_q  <= cfg_data[IP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign kind          = res.kind;
	assign mac_out       = res.mac;
	assign ip_out        = res.ip;
	assign flush_pending = res.flush;
	assign entry_index   = res.idx;

endmodule

FILE: hw/rtl/arpc_checker.sv
// Port-level checks on the ARP cache resolver result channel, with its bind.
// Depends on arpc_pkg and arp_cache_resolver_unit.
module arpc_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             done,
	input logic [arpc_pkg::KIND_W-1:0]      kind,
	input logic [arpc_pkg::MAC_W-1:0]       mac_out,
	input logic                             flush_pending,
	input logic [arpc_pkg::IDX_OUT_W-1:0]   entry_index
);
	import arpc_pkg::*;

	// the back end takes one word at a time, so results never come back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on consecutive cycles");

	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind == KIND_REPLY || kind == KIND_IGNORED)
		|-> entry_index == '0 && !flush_pending)
		else $error("reply or ignored result carries entry or flush");

	a_req_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (kind == KIND_REQ || kind == KIND_IGNORED) |-> mac_out == '0)
		else $error("request or ignored result carries a MAC");

	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		done && flush_pending |-> kind == KIND_LEARNED)
		else $error("flush outside a learned result");

endmodule

bind arp_cache_resolver_unit arpc_checker u_arpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.done          (done),
	.kind          (kind),
	.mac_out       (mac_out),
	.flush_pending (flush_pending),
	.entry_index   (entry_index)
);
